### hdl/mavg_pkg.sv
// Shared constants for the moving average filter.
// No dependencies; imported by every module of the block.
package mavg_pkg;

    // window size register
    localparam int WS_BITS = 9;
    localparam logic [WS_BITS-1:0] WS_RESET = 9'd16;

endpackage

### hdl/mavg_ring.sv
// Sample ring: single-port-write, single-port-read memory, registered read data.
// Uses mavg_pkg only for the common import convention.
module mavg_ring #(
    parameter int DEPTH = 256,
    parameter int ADDR_BITS = 8,
    parameter int DATA_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [DATA_BITS-1:0] wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [DATA_BITS-1:0] rd_data
);
    import mavg_pkg::*;

    logic [DATA_BITS-1:0] mem [DEPTH];
    logic [DATA_BITS-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

    // read and write of one request are sequenced, never in the same cycle
    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(wr_en && rd_en))
        else $error("ring read and write in the same cycle");

    a_wr_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (32'(wr_addr) < DEPTH))
        else $error("ring write address out of range");

    a_rd_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |-> (32'(rd_addr) < DEPTH))
        else $error("ring read address out of range");

endmodule

### hdl/mavg_divider.sv
// Serial signed divider: one quotient bit per cycle, truncates toward zero.
// Depends on mavg_pkg for the divisor width.
module mavg_divider #(
    parameter int SUM_BITS = 24,
    parameter int Q_BITS = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic signed [SUM_BITS-1:0]   dividend,
    input  logic [mavg_pkg::WS_BITS-1:0] divisor,
    output logic                         done,
    output logic signed [Q_BITS-1:0]    quotient
);
    import mavg_pkg::*;

    localparam int CNT_BITS = (SUM_BITS > 1) ? $clog2(SUM_BITS) : 1;

    logic                  busy_reg;
    logic [CNT_BITS-1:0]   cnt_reg;
    logic [SUM_BITS-1:0]   mag_reg;
    logic [WS_BITS-1:0]    rem_reg;
    logic [WS_BITS-1:0]    div_reg;
    logic                  neg_reg;
    logic                  done_reg;
    logic [Q_BITS-1:0]     quot_reg;

    logic [WS_BITS:0]      trial;
    logic [WS_BITS+1:0]    diff;
    logic                  ge;
    logic [SUM_BITS-1:0]   mag_next;
    logic [SUM_BITS-1:0]   quot_full;

    always_comb begin
        trial    = {rem_reg, mag_reg[SUM_BITS-1]};
        diff     = {1'b0, trial} - {2'b00, div_reg};
        ge       = !diff[WS_BITS+1];
        mag_next = {mag_reg[SUM_BITS-2:0], ge};
        quot_full = neg_reg ? (~mag_next + 1'b1) : mag_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                neg_reg  <= dividend[SUM_BITS-1];
                mag_reg  <= dividend[SUM_BITS-1] ? (~dividend + 1'b1) : dividend;
                rem_reg  <= '0;
                div_reg  <= divisor;
            end else if (busy_reg) begin
                mag_reg <= mag_next;
                rem_reg <= ge ? diff[WS_BITS-1:0] : trial[WS_BITS-1:0];
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_BITS'(SUM_BITS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    quot_reg <= quot_full[Q_BITS-1:0];
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = $signed(quot_reg);

    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> busy_reg)
        else $error("divider did not start");

    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("divider restarted while busy");

    a_done_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg && $past(busy_reg))
        else $error("divider done without a finished run");

endmodule

### hdl/moving_average_filter.sv
// Boxcar moving average: sample ring in a RAM with registered reads, exact running sum.
// One request at a time: s_ready is high only in ST_IDLE, so a request waits while the
// last one runs through the serial divider (one bit per cycle; skipped when priming or for
// a zero window) and while ST_OUT holds on a full output register not being emptied.
// A request is taken while the previous result still waits at the output.
// Reset (aresetn, synchronous, active low): window 16, unprimed, empty output. Ring RAM is
// not cleared; read data is used only from entries already written.
module moving_average_filter #(
    parameter int MAX_WINDOW = 256,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration
    input  logic                           cfg_wr_en,
    input  logic [mavg_pkg::WS_BITS-1:0]   cfg_wr_data,
    // sample requests
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [SAMPLE_BITS-1:0]  s_sample,
    // average results
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [SAMPLE_BITS-1:0]  m_average
);
    import mavg_pkg::*;

    // largest window in use: MAX_WINDOW, capped at what the 9-bit register can hold
    localparam int EFF_MAX   = (MAX_WINDOW > (2**WS_BITS - 1)) ? (2**WS_BITS - 1) : MAX_WINDOW;
    // |sample * window| fits in SAMPLE_BITS + clog2(window) bits
    localparam int SUM_BITS  = SAMPLE_BITS + $clog2(EFF_MAX);
    localparam int ADDR_BITS = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CMP_BITS  = (ADDR_BITS + 1 > WS_BITS) ? ADDR_BITS + 1 : WS_BITS;
    localparam int PROD_BITS = SAMPLE_BITS + WS_BITS + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIV,
        ST_OUT
    } state_t;

    state_t                        state_reg;
    logic [WS_BITS-1:0]            window_reg;
    logic                          primed_reg;
    logic                          wrapped_reg;
    logic [ADDR_BITS-1:0]          pos_reg;
    logic signed [SUM_BITS-1:0]    sum_reg;
    logic signed [SAMPLE_BITS-1:0] prime_reg;
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic signed [SAMPLE_BITS-1:0] result_reg;
    logic                          m_valid_reg;
    logic signed [SAMPLE_BITS-1:0] m_average_reg;

    logic [WS_BITS-1:0]            n_eff;
    logic [CMP_BITS-1:0]           n_ext;
    logic [CMP_BITS-1:0]           pos_ext;
    logic [ADDR_BITS-1:0]          pos_eff;
    logic [CMP_BITS-1:0]           pos_inc;
    logic                          pos_wrap;
    logic                          accept;
    logic                          ring_rd_en;
    logic                          ring_wr_en;
    logic [SAMPLE_BITS-1:0]        ring_rd_data;
    logic signed [SAMPLE_BITS-1:0] oldest;
    logic signed [SUM_BITS-1:0]    sum_next;
    logic signed [PROD_BITS-1:0]   prime_prod;
    logic                          div_start;
    logic                          div_done;
    logic signed [SAMPLE_BITS-1:0] div_quot;

    // window clamped to the ring depth
    assign n_eff   = (window_reg > WS_BITS'(EFF_MAX)) ? WS_BITS'(EFF_MAX) : window_reg;
    assign n_ext   = CMP_BITS'(n_eff);
    assign pos_ext = CMP_BITS'(pos_reg);

    // slot being replaced and the position after it
    assign pos_eff  = (pos_ext >= n_ext) ? '0 : pos_reg;
    assign pos_inc  = CMP_BITS'(pos_eff) + 1'b1;
    assign pos_wrap = (pos_inc >= n_ext);

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // ring read issued at acceptance, data back in ST_UPDATE where the same slot is
    // overwritten; the next read waits for ST_IDLE, so no forwarding is needed
    assign ring_rd_en = accept && primed_reg && (window_reg != '0);
    assign ring_wr_en = (state_reg == ST_UPDATE);

    assign oldest     = wrapped_reg ? $signed(ring_rd_data) : prime_reg;
    assign sum_next   = sum_reg - SUM_BITS'(oldest) + SUM_BITS'(sample_reg);
    assign prime_prod = s_sample * $signed({1'b0, n_eff});
    assign div_start  = (state_reg == ST_UPDATE);

    mavg_ring #(
        .DEPTH     (MAX_WINDOW),
        .ADDR_BITS (ADDR_BITS),
        .DATA_BITS (SAMPLE_BITS)
    ) u_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (ring_wr_en),
        .wr_addr (pos_eff),
        .wr_data (sample_reg),
        .rd_en   (ring_rd_en),
        .rd_addr (pos_eff),
        .rd_data (ring_rd_data)
    );

    mavg_divider #(
        .SUM_BITS (SUM_BITS),
        .Q_BITS   (SAMPLE_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_next),
        .divisor  (n_eff),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            window_reg  <= WS_RESET;
            primed_reg  <= 1'b0;
            wrapped_reg <= 1'b0;
            pos_reg     <= '0;
            sum_reg     <= '0;
            prime_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            // config writes must arrive only while idle (not enforced here); a new window re-arms priming
            if (cfg_wr_en) begin
                window_reg <= cfg_wr_data;
                primed_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        sample_reg <= s_sample;
                        if (window_reg == '0) begin
                            result_reg <= '0;
                            state_reg  <= ST_OUT;
                        end else if (!primed_reg) begin
                            // window taken as full of this sample
                            prime_reg   <= s_sample;
                            sum_reg     <= prime_prod[SUM_BITS-1:0];
                            pos_reg     <= '0;
                            wrapped_reg <= 1'b0;
                            primed_reg  <= 1'b1;
                            result_reg  <= s_sample;
                            state_reg   <= ST_OUT;
                        end else begin
                            state_reg <= ST_UPDATE;
                        end
                    end
                end
                ST_UPDATE: begin
                    sum_reg <= sum_next;
                    if (pos_wrap) begin
                        pos_reg     <= '0;
                        wrapped_reg <= 1'b1;
                    end else begin
                        pos_reg <= pos_inc[ADDR_BITS-1:0];
                    end
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (div_done) begin
                        result_reg <= div_quot;
                        state_reg  <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    // output register free or being emptied this cycle
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg   <= 1'b1;
                        m_average_reg <= result_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_average = m_average_reg;

    a_pos_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        primed_reg |-> (pos_ext < n_ext))
        else $error("write position beyond window while primed");

    a_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider result outside the divide state");

    a_primed_path: assert property (@(posedge aclk) disable iff (!aresetn)
        ring_rd_en |=> (state_reg == ST_UPDATE))
        else $error("ring read not followed by update");

    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_OUT))
        else $error("result presented outside the output state");

endmodule

### test/mavg_checker.sv
// Checker for the moving average filter: watches config writes, samples and results,
// predicts each window mean and compares it with what the block returns.
// Depends on mavg_pkg for the window register width and reset value.
module mavg_checker #(
    parameter int MAX_WINDOW = 256,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [mavg_pkg::WS_BITS-1:0]  cfg_wr_data,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_sample,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic signed [SAMPLE_BITS-1:0] m_average,
    output int                            err_count,
    output int                            outstanding,
    output int                            compared
);
    timeunit 1ns;
    timeprecision 1ps;
    import mavg_pkg::*;

    // filter state as the block should hold it
    logic [WS_BITS-1:0]            win_size;
    logic signed [SAMPLE_BITS-1:0] hist [MAX_WINDOW];
    longint                        window_sum;
    int unsigned                   slot;
    bit                            armed;
    logic signed [SAMPLE_BITS-1:0] fill_value;
    bit                            ring_full;

    logic signed [SAMPLE_BITS-1:0] expected_avgs[$];
    logic signed [SAMPLE_BITS-1:0] want;

    initial begin
        err_count = 0;
        outstanding = 0;
        compared = 0;
    end

    // Advance the filter by one sample and return the mean it should report.
    function automatic logic signed [SAMPLE_BITS-1:0] next_average(
        input logic signed [SAMPLE_BITS-1:0] smp
    );
        int unsigned n;
        logic signed [SAMPLE_BITS-1:0] oldest;
        longint quot;
        n = win_size;
        if (n == 0) begin
            return '0;
        end
        if (n > MAX_WINDOW) n = MAX_WINDOW;
        if (!armed) begin
            // first sample fills the whole window
            fill_value = smp;
            window_sum = longint'(smp) * longint'(n);
            slot = 0;
            ring_full = 1'b0;
            armed = 1'b1;
            return smp;
        end
        if (slot >= n) slot = 0;
        oldest = ring_full ? hist[slot] : fill_value;
        window_sum = window_sum - longint'(oldest) + longint'(smp);
        hist[slot] = smp;
        slot++;
        if (slot >= n) begin
            slot = 0;
            ring_full = 1'b1;
        end
        quot = window_sum / longint'(n);
        return quot[SAMPLE_BITS-1:0];
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            win_size = WS_RESET;
            window_sum = 0;
            slot = 0;
            armed = 1'b0;
            fill_value = '0;
            ring_full = 1'b0;
            expected_avgs.delete();
        end else begin
            if (cfg_wr_en) begin
                win_size = cfg_wr_data;
                armed = 1'b0;
            end
            // result side first, so a request taken on this edge never matches it
            if (m_valid && m_ready) begin
                if (expected_avgs.size() == 0) begin
                    err_count++;
                    $display("%0t: unexpected average %0d, nothing pending", $time,
                             m_average);
                end else begin
                    want = expected_avgs.pop_front();
                    compared++;
                    if (m_average !== want) begin
                        err_count++;
                        $display("%0t: average mismatch, expected %0d, got %0d", $time,
                                 want, m_average);
                    end
                end
            end
            if (s_valid && s_ready)
                expected_avgs.push_back(next_average(s_sample));
        end
        outstanding = expected_avgs.size();
    end

endmodule

### test/testbench.sv
// Top of the moving average filter testbench: clock, reset, sample requests, window writes
// and result back-pressure. Checking lives in mavg_checker; needs mavg_pkg and the filter.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import mavg_pkg::*;

    localparam int MAX_WINDOW = 256;
    localparam int SAMPLE_BITS = 16;
    localparam int CYCLE_LIMIT = 1_000_000;
    // cycles watched after the final drain for stray results
    localparam int TAIL_CYCLES = 40;
    localparam int NUM_PHASES = 12;

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic                          aclk;
    logic                          aresetn;
    logic                          cfg_wr_en;
    logic [WS_BITS-1:0]            cfg_wr_data;
    logic                          s_valid;
    logic                          s_ready;
    logic signed [SAMPLE_BITS-1:0] s_sample;
    logic                          m_valid;
    logic                          m_ready;
    logic signed [SAMPLE_BITS-1:0] m_average;

    int err_count;
    int outstanding;
    int compared;

    // idling knobs, percent of cycles
    int idle_pct = 0;
    int stall_pct = 0;

    int  cycle_count = 0;
    int  sent_count = 0;
    int  windows_written = 0;
    // request taken at the last rising edge
    logic s_taken = 1'b0;

    moving_average_filter #(
        .MAX_WINDOW (MAX_WINDOW),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_sample   (s_sample),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_average  (m_average)
    );

    mavg_checker #(
        .MAX_WINDOW (MAX_WINDOW),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_sample   (s_sample),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_average  (m_average),
        .err_count  (err_count),
        .outstanding(outstanding),
        .compared   (compared)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        s_taken <= s_valid && s_ready;
    end

    // watchdog: a hung handshake or a lost result ends here
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) @(posedge aclk);
        $display("timeout after %0d cycles, %0d averages still pending", cycle_count,
                 outstanding);
        $display("CHECKS FAILED");
        $finish;
    end

    // result side back-pressure, redrawn every cycle
    initial begin : result_sink
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready = ($urandom_range(99) >= stall_pct);
        end
    end

    // Idle profile per phase: none, sender gaps, receiver stalls, both.
    task automatic set_idling(input int mode);
        case (mode)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 80; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 80; end
            default: begin idle_pct = 34; stall_pct = 34; end
        endcase
    endtask

    // One sample request. Entered at a falling edge; returns at the falling edge after the
    // request was taken, with s_valid still high so back-to-back requests need no toggle.
    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] value);
        if ($urandom_range(99) < idle_pct) begin
            s_valid = 1'b0;
            do @(negedge aclk); while ($urandom_range(99) < idle_pct);
        end
        s_valid = 1'b1;
        s_sample = value;
        @(negedge aclk);
        while (!s_taken) @(negedge aclk);
        sent_count++;
    endtask

    // Stop requesting and let every pending average come back.
    task automatic drain();
        s_valid = 1'b0;
        while (outstanding != 0) @(negedge aclk);
    endtask

    // Window write, only with the block idle; it re-arms priming.
    task automatic set_window(input int w);
        drain();
        cfg_wr_en = 1'b1;
        cfg_wr_data = WS_BITS'(w);
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        windows_written++;
    endtask

    // Mix of rail values, small values around zero (truncation of negative means) and
    // full-width noise.
    function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
        case ($urandom_range(7))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return SAMPLE_BITS'(int'($urandom_range(16)) - 8);
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    // window per random phase; -1 draws a small random size
    int phase_windows[NUM_PHASES] = '{2, 256, 5, 0, 1, 511, 17, 257, -1, 3, -1, 16};

    initial begin : stimulus
        int w;
        int n;
        int count;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_valid = 1'b0;
        s_sample = '0;
        set_idling(0);
        repeat (7) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // directed: reset window of 16, priming from the positive rail, then both rails
        send_sample(SAMPLE_MAX); send_sample(SAMPLE_MAX); send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MIN); send_sample(0); send_sample(-1); send_sample(1);
        // zero window: mean is 0 and nothing moves
        set_window(0);
        send_sample(-5); send_sample(SAMPLE_MAX);
        // window of one: output follows input
        set_window(1);
        send_sample(SAMPLE_MIN); send_sample(SAMPLE_MAX); send_sample(-3);
        // size above the maximum clamps to 256; prime at the negative rail for the min sum
        set_window(511);
        send_sample(SAMPLE_MIN); send_sample(SAMPLE_MIN); send_sample(SAMPLE_MAX);
        send_sample(12345);
        // full window primed at the positive rail for the max sum
        set_window(MAX_WINDOW);
        send_sample(SAMPLE_MAX); send_sample(SAMPLE_MAX); send_sample(-7);
        // small window that wraps, so ring entries get read back
        set_window(3);
        send_sample(-1); send_sample(-2); send_sample(5); send_sample(7);
        send_sample(SAMPLE_MIN); send_sample(100);

        // random phases; big windows get enough requests to wrap
        for (int p = 0; p < NUM_PHASES; p++) begin
            w = (phase_windows[p] < 0) ? $urandom_range(40, 1) : phase_windows[p];
            n = (w > MAX_WINDOW) ? MAX_WINDOW : w;
            count = (n >= 200) ? 330 : 100;
            set_window(w);
            set_idling((p + p / 4) % 4);
            for (int i = 0; i < count; i++) send_sample(rand_sample());
        end

        // let everything return, then watch a while longer for stray results
        drain();
        set_idling(0);
        repeat (TAIL_CYCLES) @(negedge aclk);

        $display("Summary: %0d sample requests over %0d window writes, %0d averages compared",
                 sent_count, windows_written, compared);
        $display("Windows covered zero, one, small wrapping sizes, 256 and clamped sizes above");
        if (err_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### sim.f
hdl/mavg_pkg.sv
hdl/mavg_ring.sv
hdl/mavg_divider.sv
hdl/moving_average_filter.sv
test/mavg_checker.sv
test/testbench.sv
